@@ rtl/core/sha256_hash_engine_assert.svh @@
// Assertion macros shared by the hash engine modules.
// Both expect a signal named clk in the scope of use; SHA_ASSERT also needs arst_n.
`ifndef SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA256_HASH_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SHA_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, prop, msg)
`define SHA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ rtl/core/sha_pkg.sv @@
package sha_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       push_en;
		logic       push_word;
		logic [7:0] push_byte;
		logic       work_load;
		logic       round_en;
		logic [5:0] round_idx;
		logic       hash_fold;
		logic       hash_init;
		logic [2:0] word_idx;
	} ctl_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] POS_LAST = 6'd63;
	localparam logic [5:0] POS_LEN = 6'd56;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST = 3'd7;

	function automatic logic [31:0] ror(input logic [31:0] v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	function automatic logic [31:0] big0(input logic [31:0] v);
		return ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
	endfunction

	function automatic logic [31:0] big1(input logic [31:0] v);
		return ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] v);
		return ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] v);
		return ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0:    r = 32'h6a09e667;
			3'd1:    r = 32'hbb67ae85;
			3'd2:    r = 32'h3c6ef372;
			3'd3:    r = 32'ha54ff53a;
			3'd4:    r = 32'h510e527f;
			3'd5:    r = 32'h9b05688c;
			3'd6:    r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] r;
		case (t)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/sha_sched.sv @@
module sha_sched (
	input  logic          clk,
	input  sha_pkg::ctl_t ctl,
	output logic [31:0]   wt
);
	import sha_pkg::*;

	logic [23:0] acc_q;
	logic [31:0] win_q [16];
	logic [31:0] next_w;

	always_comb begin
		next_w = sig1(win_q[14]) + win_q[9] + sig0(win_q[1]) + win_q[0];
	end

	assign wt = win_q[0];

	// Pack bytes big-endian; a finished word enters the window at the top.
	always_ff @(posedge clk) begin
		if (ctl.push_en) begin
			if (ctl.push_word) begin
				for (int i = 0; i < 15; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[15] <= {acc_q, ctl.push_byte};
			end else begin
				acc_q <= {acc_q[15:0], ctl.push_byte};
			end
		end else if (ctl.round_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= next_w;
		end
	end

endmodule

@@ rtl/core/sha_round.sv @@
module sha_round (
	input  logic          clk,
	input  logic          arst_n,
	input  sha_pkg::ctl_t ctl,
	input  logic [31:0]   wt,
	output logic [31:0]   hash_word
);
	import sha_pkg::*;

	logic [31:0] work_q [8];
	logic [31:0] hash_q [8];
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] chs;
	logic [31:0] mj;

	always_comb begin
		chs = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		mj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1 = work_q[7] + big1(work_q[4]) + chs + round_k(ctl.round_idx) + wt;
		t2 = big0(work_q[0]) + mj;
	end

	always_ff @(posedge clk) begin
		if (ctl.work_load) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= hash_q[i];
			end
		end else if (ctl.round_en) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= init_hash(3'(i));
			end
		end else if (ctl.hash_init) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= init_hash(3'(i));
			end
		end else if (ctl.hash_fold) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + work_q[i];
			end
		end
	end

	assign hash_word = hash_q[ctl.word_idx];

endmodule

@@ rtl/core/sha_ctrl.sv @@
`include "sha256_hash_engine_assert.svh"

module sha_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	output logic          msg_stall,
	input  sha_pkg::msg_t msg,
	input  logic          out_free,
	output logic          out_load,
	output sha_pkg::ctl_t ctl
);
	import sha_pkg::*;

	state_t      state_q;
	state_t      state_d;
	logic [5:0]  pos_q;
	logic [60:0] cnt_q;
	logic [5:0]  round_q;
	logic [2:0]  widx_q;
	logic        pad_q;
	logic        first_q;
	logic        len_q;
	logic        final_q;

	logic        accept;
	logic        len_sel;
	logic        pos_last;
	logic        out_done;
	logic [63:0] bit_cnt;
	logic [7:0]  len_byte;

	always_comb begin
		accept = msg_valid && (state_q == ST_IDLE);
		pos_last = (pos_q == POS_LAST);
		len_sel = len_q || ((pos_q == POS_LEN) && !first_q);
		bit_cnt = {cnt_q, 3'b000};
		len_byte = 8'(bit_cnt >> {3'(WORD_LAST - pos_q[2:0]), 3'b000});
		out_done = out_load && (widx_q == WORD_LAST);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (msg.has_byte && pos_last) begin
						state_d = ST_COMP;
					end else if (msg.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (pos_last) begin
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				if (round_q == ROUND_LAST) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (final_q) begin
					state_d = ST_OUT;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		msg_stall = (state_q != ST_IDLE);
		out_load = (state_q == ST_OUT) && out_free;
		ctl = '0;
		ctl.round_idx = round_q;
		ctl.word_idx = widx_q;
		ctl.push_word = (pos_q[1:0] == 2'b11);
		case (state_q)
			ST_IDLE: begin
				ctl.push_en = accept && msg.has_byte;
				ctl.push_byte = msg.data_byte;
			end
			ST_PAD: begin
				ctl.push_en = 1'b1;
				if (first_q) begin
					ctl.push_byte = PAD_MARK;
				end else if (len_sel) begin
					ctl.push_byte = len_byte;
				end
			end
			ST_COMP: ctl.round_en = 1'b1;
			ST_FIN:  ctl.hash_fold = 1'b1;
			ST_OUT:  ctl.hash_init = out_done;
			default: ;
		endcase
		ctl.work_load = ctl.push_en && pos_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			cnt_q <= '0;
			round_q <= '0;
			widx_q <= '0;
			pad_q <= 1'b0;
			first_q <= 1'b0;
			len_q <= 1'b0;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.push_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (ctl.round_en) begin
				round_q <= round_q + 6'd1;
			end
			if (out_load) begin
				widx_q <= widx_q + 3'd1;
			end
			if (accept && msg.has_byte) begin
				cnt_q <= cnt_q + 61'd1;
			end
			if (accept && msg.end_of_message) begin
				pad_q <= 1'b1;
				first_q <= 1'b1;
			end
			if (state_q == ST_PAD) begin
				first_q <= 1'b0;
				// hold the length phase once it starts
				if (!first_q && len_sel) begin
					len_q <= 1'b1;
					if (pos_last) begin
						final_q <= 1'b1;
					end
				end
			end
			if (out_done) begin
				cnt_q <= '0;
				pad_q <= 1'b0;
				len_q <= 1'b0;
				final_q <= 1'b0;
			end
		end
	end

	`SHA_ASSERT(a_fin_wrap, (state_q == ST_FIN) |-> (round_q == '0), "round count not wrapped at fold")
	`SHA_ASSERT(a_comp_aligned, (state_q == ST_COMP) |-> (pos_q == '0), "compression on partial block")
	`SHA_ASSERT(a_out_aligned, (state_q == ST_OUT) |-> (pos_q == '0 && final_q), "digest before final block")

endmodule

@@ rtl/core/sha256_hash_engine.sv @@
// SHA-256 streaming hash engine.
// Input channel msg: one transaction per message byte (has_byte) and/or end
// mark (end_of_message). Bytes fill 64-byte blocks big-endian. Output channel
// digest: eight transactions per closed message, word 0 (most significant)
// first, last_word set on word 7.
// Flow: bytes are taken while the block is filling; each full block then
// holds msg_stall high while the single round unit runs the rounds and the
// result folds into the hash, so no new byte is taken during compression.
// End of message: padding bytes are generated one per cycle up to the next
// block end (one or two final blocks, each compressed the same way), then
// the eight words are loaded into the output register, one per cycle when
// the receiver does not stall. The next message is taken once word 7 is
// loaded, even while it still waits in the output register.
// A digest_stall holds the output register and pauses word readout.
// Reset (arst_n low, asynchronous) restores the initial hash value, clears
// the byte and length counters and drops digest_valid.
`include "sha256_hash_engine_assert.svh"

module sha256_hash_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             msg_valid,
	output logic             msg_stall,
	input  sha_pkg::msg_t    msg,
	output logic             digest_valid,
	input  logic             digest_stall,
	output sha_pkg::digest_t digest
);
	import sha_pkg::*;

	ctl_t        ctl;
	logic        out_load;
	logic        out_free;
	logic [31:0] wt;
	logic [31:0] hash_word;
	logic        out_valid_q;
	digest_t     out_q;

	assign out_free = !out_valid_q || !digest_stall;

	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.out_free  (out_free),
		.out_load  (out_load),
		.ctl       (ctl)
	);

	sha_sched u_sched (
		.clk (clk),
		.ctl (ctl),
		.wt  (wt)
	);

	sha_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.wt        (wt),
		.hash_word (hash_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!digest_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.digest_word <= hash_word;
			out_q.word_index <= ctl.word_idx;
			out_q.last_word <= (ctl.word_idx == WORD_LAST);
		end
	end

	assign digest_valid = out_valid_q;
	assign digest = out_q;

	`SHA_ASSERT_RST(a_rst_quiet, (!arst_n) |-> !digest_valid, "digest valid during reset")
	`SHA_ASSERT(a_last_idx, (digest_valid && digest.last_word) |-> (digest.word_index == WORD_LAST), "last mark off word 7")

endmodule

@@ test/sha256_digest_checker.sv @@
module sha256_digest_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             msg_valid,
	input  logic             msg_stall,
	input  sha_pkg::msg_t    msg,
	input  logic             digest_valid,
	input  logic             digest_stall,
	input  sha_pkg::digest_t digest,
	output int               mismatches,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [0:7][31:0] HASH_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] ROUND_CONST = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic [31:0] chain [8];
	logic [31:0] window [16];
	logic [5:0]  fill_pos;
	logic [63:0] bit_total;
	sha_pkg::digest_t expected_words [$];
	int          err_count;

	assign mismatches = err_count;

	function automatic logic [31:0] rot_r(input logic [31:0] x, input int n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	function automatic logic [31:0] sched_s0(input logic [31:0] x);
		return rot_r(x, 7) ^ rot_r(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sched_s1(input logic [31:0] x);
		return rot_r(x, 17) ^ rot_r(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] mix_a(input logic [31:0] x);
		return rot_r(x, 2) ^ rot_r(x, 13) ^ rot_r(x, 22);
	endfunction

	function automatic logic [31:0] mix_e(input logic [31:0] x);
		return rot_r(x, 6) ^ rot_r(x, 11) ^ rot_r(x, 25);
	endfunction

	task automatic clear_state();
		for (int i = 0; i < 8; i++)
			chain[i] = HASH_INIT[i];
		for (int i = 0; i < 16; i++)
			window[i] = '0;
		fill_pos = '0;
		bit_total = '0;
		expected_words.delete();
	endtask

	task automatic compress();
		logic [31:0] v [8];
		logic [31:0] wt;
		logic [31:0] t1;
		logic [31:0] t2;
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int t = 0; t < 64; t++) begin
			// expand the schedule in place over a 16-word window
			if (t < 16) begin
				wt = window[t];
			end else begin
				wt = window[t % 16] + sched_s0(window[(t + 1) % 16])
					+ window[(t + 9) % 16] + sched_s1(window[(t + 14) % 16]);
				window[t % 16] = wt;
			end
			t1 = v[7] + mix_e(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
				+ ROUND_CONST[t] + wt;
			t2 = mix_a(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endtask

	task automatic absorb(input logic [7:0] b);
		int shift;
		shift = 24 - 8 * fill_pos[1:0];
		if (fill_pos[1:0] == 2'd0)
			window[fill_pos[5:2]] = '0;
		window[fill_pos[5:2]] = window[fill_pos[5:2]] | ({24'd0, b} << shift);
		fill_pos = fill_pos + 6'd1;
		if (fill_pos == 6'd0)
			compress();
	endtask

	task automatic close_message();
		sha_pkg::digest_t d;
		absorb(sha_pkg::PAD_MARK);
		while (fill_pos != sha_pkg::POS_LEN)
			absorb(8'h00);
		window[14] = bit_total[63:32];
		window[15] = bit_total[31:0];
		fill_pos = '0;
		compress();
		for (int i = 0; i < 8; i++) begin
			d.digest_word = chain[i];
			d.word_index = 3'(i);
			d.last_word = (d.word_index == sha_pkg::WORD_LAST);
			expected_words.push_back(d);
		end
		for (int i = 0; i < 8; i++)
			chain[i] = HASH_INIT[i];
		bit_total = '0;
	endtask

	task automatic check_word(input sha_pkg::digest_t got);
		sha_pkg::digest_t want;
		if (expected_words.size() == 0) begin
			err_count++;
			if (err_count <= 10)
				$display("unexpected digest word %h index %0d last %0b",
					got.digest_word, got.word_index, got.last_word);
			return;
		end
		want = expected_words.pop_front();
		if (got.digest_word !== want.digest_word || got.word_index !== want.word_index
			|| got.last_word !== want.last_word) begin
			err_count++;
			if (err_count <= 10)
				$display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
					want.digest_word, want.word_index, want.last_word,
					got.digest_word, got.word_index, got.last_word);
		end
	endtask

	initial err_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			// retire output first: a word leaving now never belongs to this input
			if (digest_valid && !digest_stall)
				check_word(digest);
			if (msg_valid && !msg_stall) begin
				if (msg.has_byte) begin
					absorb(msg.data_byte);
					bit_total = bit_total + 64'd8;
				end
				if (msg.end_of_message)
					close_message();
			end
		end
		pending <= expected_words.size();
	end

endmodule

@@ test/tb_sha256_hash_engine.sv @@
module tb_sha256_hash_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 400000;
	localparam int LONG_HOLD = 400;
	localparam int PHASE_ITEMS = 20;

	logic             clk;
	logic             arst_n;
	logic             msg_valid;
	logic             msg_stall;
	sha_pkg::msg_t    msg;
	logic             digest_valid;
	logic             digest_stall;
	sha_pkg::digest_t digest;
	int               mismatches;
	int               pending;

	int src_idle_pct;
	int sink_stall_pct;
	int long_holds_wanted;
	int items_sent;
	int cycles;

	sha256_hash_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	sha256_digest_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("sha256_hash_engine test failed");
				$finish;
			end
		end
	end

	function automatic sha_pkg::msg_t make_item(input logic [7:0] b, input logic has,
		input logic eom);
		sha_pkg::msg_t m;
		m.data_byte = b;
		m.has_byte = has;
		m.end_of_message = eom;
		return m;
	endfunction

	// offer one transaction and hold it until taken
	task automatic send_item(input sha_pkg::msg_t m);
		while ($urandom_range(99) < src_idle_pct) begin
			msg_valid <= 1'b0;
			@(negedge clk);
		end
		msg_valid <= 1'b1;
		msg <= m;
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
		if (m.has_byte || m.end_of_message)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(input int len);
		logic end_apart;
		end_apart = (len == 0) || ($urandom_range(3) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
			send_item(make_item(8'($urandom_range(255)), 1'b1,
				(i == len - 1) && !end_apart));
		end
		if (end_apart)
			send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b1));
	endtask

	// receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		digest_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (holds_done != long_holds_wanted) begin
				holds_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				digest_stall <= 1'b1;
			end else begin
				digest_stall <= ($urandom_range(99) < sink_stall_pct);
			end
		end
	end

	initial begin
		int len;
		int phase_start;
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		long_holds_wanted = 0;
		items_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty message, ignored bytes, byte extremes, split end mark
		send_item(make_item(8'hff, 1'b0, 1'b1));
		send_item(make_item(8'ha5, 1'b0, 1'b0));
		send_item(make_item(8'h5a, 1'b0, 1'b0));
		send_item(make_item(8'h00, 1'b1, 1'b0));
		send_item(make_item(8'hff, 1'b1, 1'b0));
		send_item(make_item(8'h80, 1'b1, 1'b1));
		send_item(make_item(8'h61, 1'b1, 1'b0));
		send_item(make_item(8'hc3, 1'b0, 1'b0));
		send_item(make_item(8'h62, 1'b1, 1'b0));
		send_item(make_item(8'h63, 1'b1, 1'b0));
		send_item(make_item(8'h3c, 1'b0, 1'b1));
		send_item(make_item(8'hff, 1'b1, 1'b1));
		send_item(make_item(8'h00, 1'b0, 1'b1));
		send_item(make_item(8'h00, 1'b0, 1'b1));

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
					long_holds_wanted++;
				end
				1: begin
					src_idle_pct = 64;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 64;
				end
				default: begin
					src_idle_pct = 33;
					sink_stall_pct = 33;
				end
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				// mostly short messages, some on the padding boundaries
				if ($urandom_range(4) == 0) begin
					case ($urandom_range(4))
						0:       len = 55;
						1:       len = 56;
						2:       len = 63;
						3:       len = 64;
						default: len = 65;
					endcase
				end else begin
					len = $urandom_range(9);
				end
				send_message(len);
			end
		end
		msg_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("sha256_hash_engine test passed");
		else
			$display("sha256_hash_engine test failed");
		$finish;
	end

endmodule
